// ===== src/lru_pkg.sv =====
// Package for the LRU order list: sizes, payload structs, state encoding and
// the per-cell control struct. Used by lru_cell and lru_order_list_core.
package lru_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned KeyW  = 32;
  localparam int unsigned CapW  = 5;

  localparam logic KIND_ACCESS = 1'b0;
  localparam logic KIND_DUMP   = 1'b1;

  typedef struct packed {
    logic                   kind;
    logic signed [KeyW-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic                   result_kind;
    logic                   hit;
    logic                   evicted;
    logic signed [KeyW-1:0] out_key;
    logic                   entry_valid;
    logic                   last;
  } out_item_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_e;

endpackage

// ===== src/lru_cell.sv =====
// One position of the LRU list: holds a key, compares it against the probe
// key and takes either its younger neighbour's key or the new key. Uses lru_pkg.
module lru_cell import lru_pkg::*; (
  input  logic                   clk_i,
  input  cell_ctrl_t             ctrl_i,
  input  logic signed [KeyW-1:0] neighbour_key_i,
  input  logic signed [KeyW-1:0] new_key_i,
  input  logic signed [KeyW-1:0] probe_key_i,
  output logic signed [KeyW-1:0] key_o,
  output logic                   match_o
);

  logic signed [KeyW-1:0] key_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      key_q <= new_key_i;
    end else if (ctrl_i.shift) begin
      key_q <= neighbour_key_i;
    end
  end

  assign key_o   = key_q;
  assign match_o = (key_q == probe_key_i);

endmodule

// ===== src/lru_order_list_core.sv =====
// Top level of the LRU order list: a row of key cells with a shared probe,
// occupancy and capacity registers, dump sequencer and output register.
// Depends on lru_pkg and lru_cell.
module lru_order_list_core import lru_pkg::*; (
  // An access is accepted on an input transfer and its report is ready in the
  // next cycle, so back-to-back accesses run at one per cycle while the output
  // is taken. A dump transfer is accepted, and then the list is read out most
  // recent first, one entry per cycle while the output is taken, through the
  // single read port of the cell row; no input is taken meanwhile. Keys are
  // held in a chain of cells that all compare the probe key in parallel and
  // shift towards the oldest end on a hit or an eviction. Capacity must be
  // written only while idle; the block itself does not enforce it. Zero acts
  // as one and values above the depth act as the depth.
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [CapW-1:0] cfg_data_i
);

  state_e                 state_q, state_d;
  logic [CntW-1:0]        occ_q, occ_d;
  logic [CapW-1:0]        cap_q;
  logic [IdxW-1:0]        rd_idx_q, rd_idx_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_q, out_d;

  logic signed [KeyW-1:0] cell_key [Depth];
  logic [Depth-1:0]       match;
  logic [Depth-1:0]       hit_vec;
  cell_ctrl_t             ctrl [Depth];

  logic                   slot_free;
  logic                   in_fire;
  logic                   acc_fire;
  logic                   dump_fire;
  logic                   hit;
  logic                   evict;
  logic [IdxW-1:0]        hit_idx;
  logic [CntW-1:0]        eff_cap;
  logic [CntW-1:0]        load_pos;
  logic [CntW-1:0]        top_pos;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && slot_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign acc_fire   = in_fire && (in_data_i.kind == KIND_ACCESS);
  assign dump_fire  = in_fire && (in_data_i.kind == KIND_DUMP);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CntW'(1);
    end else if (CntW'(cap_q) > CntW'(Depth)) begin
      eff_cap = CntW'(Depth);
    end else begin
      eff_cap = CntW'(cap_q);
    end
  end

  always_comb begin
    hit_idx = '0;
    for (int j = 0; j < Depth; j++) begin
      hit_vec[j] = match[j] && (CntW'(j) < occ_q);
      if (hit_vec[j]) begin
        hit_idx = hit_idx | IdxW'(j);
      end
    end
  end

  assign hit      = |hit_vec;
  assign evict    = !hit && (occ_q >= eff_cap);
  assign top_pos  = occ_q - CntW'(1);
  assign load_pos = (hit || evict) ? top_pos : occ_q;

  always_comb begin
    for (int j = 0; j < Depth; j++) begin
      ctrl[j].load  = acc_fire && (CntW'(j) == load_pos);
      ctrl[j].shift = acc_fire && (CntW'(j) < top_pos)
                      && ((hit && (IdxW'(j) >= hit_idx)) || evict);
    end
  end

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    logic signed [KeyW-1:0] neighbour;
    if (g == Depth - 1) begin : g_end
      assign neighbour = in_data_i.key;
    end else begin : g_mid
      assign neighbour = cell_key[g+1];
    end
    lru_cell u_cell (
      .clk_i          (clk_i),
      .ctrl_i         (ctrl[g]),
      .neighbour_key_i(neighbour),
      .new_key_i      (in_data_i.key),
      .probe_key_i    (in_data_i.key),
      .key_o          (cell_key[g]),
      .match_o        (match[g])
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (dump_fire && (occ_q != '0)) begin
          state_d = ST_DUMP;
        end
      end
      ST_DUMP: begin
        if (slot_free && (rd_idx_q == '0)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    rd_idx_d    = rd_idx_q;
    occ_d       = occ_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc_fire) begin
          out_valid_d       = 1'b1;
          out_d             = '0;
          out_d.result_kind = KIND_ACCESS;
          out_d.hit         = hit;
          out_d.evicted     = evict;
          out_d.out_key     = evict ? cell_key[0] : '0;
          out_d.last        = 1'b1;
          if (!hit && !evict) begin
            occ_d = occ_q + CntW'(1);
          end
        end else if (dump_fire) begin
          rd_idx_d = top_pos[IdxW-1:0];
          if (occ_q == '0) begin
            out_valid_d       = 1'b1;
            out_d             = '0;
            out_d.result_kind = KIND_DUMP;
            out_d.last        = 1'b1;
          end
        end
      end
      ST_DUMP: begin
        if (slot_free) begin
          out_valid_d       = 1'b1;
          out_d             = '0;
          out_d.result_kind = KIND_DUMP;
          out_d.out_key     = cell_key[rd_idx_q];
          out_d.entry_valid = 1'b1;
          out_d.last        = (rd_idx_q == '0);
          rd_idx_d          = rd_idx_q - IdxW'(1);
        end
      end
      default: begin
        out_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      occ_q       <= '0;
      cap_q       <= CapW'(Depth);
      out_valid_q <= 1'b0;
      rd_idx_q    <= '0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
      rd_idx_q    <= rd_idx_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CntW'(Depth))
    else $error("occupancy above depth");

  a_unique_keys: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && (in_data_i.kind == KIND_ACCESS) |-> $onehot0(hit_vec))
    else $error("key held in more than one cell");

  a_dump_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DUMP |-> !in_ready_o)
    else $error("input taken during dump");

  a_access_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_fire |=> out_valid_q && out_q.last && (out_q.result_kind == KIND_ACCESS))
    else $error("access transfer gave no report");

endmodule

// ===== verif/tb_lru_order_list_core.sv =====
// Self-checking testbench for lru_order_list_core: directed and random access and dump
// traffic under several capacity settings, checked against a built-in predictor.
// Depends on lru_pkg and the RTL of lru_order_list_core.
module tb_lru_order_list_core;
  import lru_pkg::*;

  localparam int unsigned SettleCycles = Depth + 4;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned PhaseItems   = 55;
  localparam int unsigned PoolMax      = 20;
  localparam int unsigned IdlePercent  = 34;

  class lru_list_board;
    out_item_t              expected_results[$];
    logic signed [KeyW-1:0] held_keys[Depth];
    int                     held_count;
    logic [CapW-1:0]        capacity;
    int                     errors;
    int                     items_seen;
    int                     dumps_seen;
    int                     hits_seen;
    int                     evictions_seen;
    int                     results_checked;

    function new();
      held_count = 0;
      capacity   = CapW'(16);
      errors     = 0;
    endfunction

    function int usable_capacity();
      if (capacity == 0) return 1;
      if (capacity > Depth) return Depth;
      return capacity;
    endfunction

    function void note_capacity(logic [CapW-1:0] value);
      capacity = value;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void queue_result(out_item_t r);
      expected_results.insert(expected_results.size(), r);
    endfunction

    // Works out the results of one accepted input transfer and queues them.
    function void note_item(in_item_t item);
      out_item_t r;
      int        i;
      int        pos;
      items_seen++;
      r = '0;
      if (item.kind == KIND_DUMP) begin
        dumps_seen++;
        r.result_kind = KIND_DUMP;
        if (held_count == 0) begin
          r.last = 1'b1;
          queue_result(r);
        end else begin
          for (i = held_count; i > 0; i--) begin
            r.out_key     = held_keys[i-1];
            r.entry_valid = 1'b1;
            r.last        = (i == 1);
            queue_result(r);
          end
        end
        return;
      end
      r.result_kind = KIND_ACCESS;
      r.last        = 1'b1;
      pos = held_count;
      for (i = 0; i < held_count; i++) begin
        if (held_keys[i] == item.key) begin
          pos = i;
          break;
        end
      end
      if (pos < held_count) begin
        for (i = pos; i + 1 < held_count; i++) held_keys[i] = held_keys[i+1];
        held_keys[held_count-1] = item.key;
        r.hit = 1'b1;
        hits_seen++;
      end else begin
        if (held_count >= usable_capacity()) begin
          r.evicted = 1'b1;
          r.out_key = held_keys[0];
          for (i = 0; i + 1 < held_count; i++) held_keys[i] = held_keys[i+1];
          held_count--;
          evictions_seen++;
        end
        if (held_count < Depth) begin
          held_keys[held_count] = item.key;
          held_count++;
        end
      end
      queue_result(r);
    endfunction

    task report(string what);
      errors++;
      if (errors <= 200) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("result transfer with nothing expected: %p", got));
        return;
      end
      want = expected_results[0];
      expected_results.delete(0);
      results_checked++;
      if (got.result_kind !== want.result_kind)
        report($sformatf("result_kind %b, expected %b", got.result_kind, want.result_kind));
      if (got.hit !== want.hit)
        report($sformatf("hit %b, expected %b", got.hit, want.hit));
      if (got.evicted !== want.evicted)
        report($sformatf("evicted %b, expected %b", got.evicted, want.evicted));
      if (got.out_key !== want.out_key)
        report($sformatf("out_key %h, expected %h", got.out_key, want.out_key));
      if (got.entry_valid !== want.entry_valid)
        report($sformatf("entry_valid %b, expected %b", got.entry_valid, want.entry_valid));
      if (got.last !== want.last)
        report($sformatf("last %b, expected %b", got.last, want.last));
    endtask
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_ready_o;
  in_item_t        in_data_i;
  logic            out_valid_o;
  logic            out_ready_i;
  out_item_t       out_data_o;
  logic            cfg_valid_i;
  logic            cfg_ready_o;
  logic [CapW-1:0] cfg_data_i;

  lru_list_board board;
  logic          steady_stretch;
  int unsigned   cycle_count;
  int            settings_used;

  lru_order_list_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_ready_i <= steady_stretch || ($urandom_range(0, 99) >= IdlePercent);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_result(out_data_o);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, board.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_item(input logic kind, input logic signed [KeyW-1:0] key);
    in_item_t item;
    item.kind = kind;
    item.key  = key;
    while (!steady_stretch && $urandom_range(0, 99) < IdlePercent) @(negedge clk_i);
    in_data_i  = item;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_item(item);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic wait_drained();
    while (board.pending() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_capacity(input logic [CapW-1:0] value);
    wait_drained();
    cfg_data_i  = value;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.note_capacity(value);
    settings_used++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin
    logic [CapW-1:0]        phase_caps[8];
    logic signed [KeyW-1:0] pool[PoolMax];
    int                     pool_size;
    int                     phase;
    int                     n;
    logic signed [KeyW-1:0] key;

    board          = new();
    steady_stretch = 1'b0;
    settings_used  = 0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: empty dump, extreme keys, hits, evictions and ignored dump keys.
    set_capacity(CapW'(3));
    send_item(KIND_DUMP, 32'sh0000_0000);
    send_item(KIND_ACCESS, 32'sh8000_0000);
    send_item(KIND_ACCESS, 32'sh7fff_ffff);
    send_item(KIND_ACCESS, 32'sh0000_0000);
    send_item(KIND_DUMP, 32'shffff_ffff);
    send_item(KIND_ACCESS, 32'sh7fff_ffff);
    send_item(KIND_ACCESS, 32'shffff_ffff);
    send_item(KIND_ACCESS, 32'sh8000_0000);
    send_item(KIND_DUMP, 32'sh5a5a_a5a5);
    send_item(KIND_ACCESS, 32'shffff_ffff);
    send_item(KIND_ACCESS, 32'sh5555_5555);
    send_item(KIND_ACCESS, 32'shaaaa_aaaa);
    send_item(KIND_ACCESS, 32'shaaaa_aaaa);
    send_item(KIND_DUMP, 32'sh8000_0000);

    // Small settings first, so that the list is held above capacity for a while.
    phase_caps = '{CapW'(0), CapW'(1), CapW'(2), CapW'(5),
                   CapW'(31), CapW'(17), CapW'(12), CapW'(16)};
    for (phase = 0; phase < 8; phase++) begin
      set_capacity(phase_caps[phase]);
      pool_size = board.usable_capacity() + 4;
      if (pool_size > PoolMax) pool_size = PoolMax;
      for (n = 0; n < PoolMax; n++) pool[n] = $urandom;
      if (phase % 2 == 1) begin
        pool[0] = 32'sh8000_0000;
        pool[1] = 32'sh7fff_ffff;
      end
      steady_stretch = (phase == 5);
      for (n = 0; n < PhaseItems; n++) begin
        if (phase == 3 && n == PhaseItems / 2) wait_drained();
        if ($urandom_range(0, 3) != 0) key = pool[$urandom_range(0, pool_size - 1)];
        else key = $urandom;
        send_item(($urandom_range(0, 99) < 10) ? KIND_DUMP : KIND_ACCESS, key);
      end
    end
    steady_stretch = 1'b0;

    wait_drained();
    if (board.pending() != 0)
      board.report($sformatf("%0d results never arrived", board.pending()));
    $display("Run covered %0d input items (%0d dumps) over %0d capacity settings,",
             board.items_seen, board.dumps_seen, settings_used);
    $display("with %0d hits, %0d evictions and %0d result transfers checked.",
             board.hits_seen, board.evictions_seen, board.results_checked);
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/lru_pkg.sv
src/lru_cell.sv
src/lru_order_list_core.sv
verif/tb_lru_order_list_core.sv
